/* hw/rtl/drc_pkg.sv */
package drc_pkg;

  localparam int unsigned ENTRIES_DEF = 256;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned BLK_W    = 64;
  localparam int unsigned REF_W    = 32;
  localparam int unsigned TOT_W    = 64;
  localparam int unsigned BS_W     = 17;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned DMODE_W  = 2;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // key memory word: valid flag above the checksum
  localparam int unsigned KMEM_W = KEY_W + 1;
  // data memory word: block number above the reference count
  localparam int unsigned DMEM_W = BLK_W + REF_W;

  localparam logic [DMODE_W-1:0] DMODE_BLOCK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd2;

  localparam logic               ENABLED_RST    = 1'b0;
  localparam logic [DMODE_W-1:0] MODE_RST       = 2'd1;
  localparam logic [BS_W-1:0]    BLOCK_SIZE_RST = 17'd4096;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD  = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic               enabled;
    logic [DMODE_W-1:0] dmode;
    logic [BS_W-1:0]    block_size;
  } cfg_t;

  typedef struct packed {
    logic [TOT_W-1:0] saved;
    logic [TOT_W-1:0] shared;
  } sts_t;

endpackage

/* hw/rtl/drc_ifs.sv */
interface drc_in_if;
  import drc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    mode;
  logic [KEY_W-1:0]   checksum;
  logic [BLK_W-1:0]   block_number;

  modport source (output valid, mode, checksum, block_number, input ready);
  modport sink (input valid, mode, checksum, block_number, output ready);
endinterface

interface drc_out_if;
  import drc_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [BLK_W-1:0]   found_block;
  logic [REF_W-1:0]   ref_count;
  logic [TOT_W-1:0]   bytes_saved;
  logic [TOT_W-1:0]   shared_blocks;

  modport source (
    output valid, status, found_block, ref_count, bytes_saved, shared_blocks,
    input ready
  );
  modport sink (
    input valid, status, found_block, ref_count, bytes_saved, shared_blocks,
    output ready
  );
endinterface

/* hw/rtl/drc_ram.sv */
module drc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/drc_engine.sv */
module drc_engine #(
  parameter int unsigned ENTRIES = drc_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  drc_pkg::cfg_t              cfg_i,
  drc_in_if.sink                     in_i,
  drc_out_if.source                  out_o,
  output logic                       key_we_o,
  output logic [drc_pkg::KMEM_W-1:0] key_wdata_o,
  output logic                       dat_we_o,
  output logic [drc_pkg::DMEM_W-1:0] dat_wdata_o,
  output logic [$clog2(ENTRIES)-1:0] waddr_o,
  output logic                       re_o,
  output logic [$clog2(ENTRIES)-1:0] raddr_o,
  input  logic [drc_pkg::KMEM_W-1:0] key_rdata_i,
  input  logic [drc_pkg::DMEM_W-1:0] dat_rdata_i,
  output drc_pkg::sts_t              sts_o
);
  import drc_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [AW:0]   SCAN_END = (AW + 1)'(ENTRIES);

  state_e state_q, state_d;

  logic [AW-1:0]    clr_q, clr_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [AW:0]      scan_q, scan_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]    cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [AW-1:0]    hit_idx_q, hit_idx_d;
  logic [BLK_W-1:0] hit_blk_q, hit_blk_d;
  logic [REF_W-1:0] hit_refs_q, hit_refs_d;
  logic             free_vld_q, free_vld_d;
  logic [AW-1:0]    free_idx_q, free_idx_d;
  status_e          res_status_q, res_status_d;
  logic [BLK_W-1:0] res_blk_q, res_blk_d;
  logic [REF_W-1:0] res_refs_q, res_refs_d;
  logic [TOT_W-1:0] saved_q, saved_d;
  logic [TOT_W-1:0] shared_q, shared_d;

  logic             ov_q, ov_d;
  logic [ST_W-1:0]  o_status_q, o_status_d;
  logic [BLK_W-1:0] o_blk_q, o_blk_d;
  logic [REF_W-1:0] o_refs_q, o_refs_d;
  logic [TOT_W-1:0] o_saved_q, o_saved_d;
  logic [TOT_W-1:0] o_shared_q, o_shared_d;

  logic             accept;
  logic             need_scan;
  status_e          early_status;
  logic             rd_valid;
  logic [KEY_W-1:0] rd_key;
  logic             match;
  logic             last;
  logic             issue;
  logic             can_load;
  logic [REF_W-1:0] refs_inc;
  logic [REF_W-1:0] refs_dec;

  assign accept   = in_i.valid && in_i.ready;
  assign rd_valid = key_rdata_i[KEY_W];
  assign rd_key   = key_rdata_i[KEY_W-1:0];
  assign match    = cmp_vld_q && rd_valid && (rd_key == key_q);
  assign last     = cmp_vld_q && (cmp_idx_q == LAST_IDX);
  assign issue    = (state_q == S_SCAN) && (scan_q < SCAN_END);
  assign can_load = !ov_q || out_o.ready;
  assign refs_inc = (hit_refs_q == REF_MAX) ? hit_refs_q : hit_refs_q + 1'b1;
  assign refs_dec = hit_refs_q - 1'b1;

  // decide whether the word needs a table search
  always_comb begin
    need_scan    = 1'b0;
    early_status = ST_INVALID;
    case (in_i.mode)
      OP_RECORD: begin
        if (in_i.block_number == '0) begin
          early_status = ST_INVALID;
        end else if (cfg_i.enabled && (cfg_i.dmode >= DMODE_BLOCK)) begin
          need_scan = 1'b1;
        end else begin
          early_status = ST_OK;
        end
      end
      OP_RESOLVE: begin
        need_scan = cfg_i.enabled;
      end
      OP_RELEASE: begin
        need_scan = (in_i.checksum != '0);
      end
      default: begin
        need_scan = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = need_scan ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        if (match || last) state_d = S_UPD;
      end
      S_UPD: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (can_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    op_d         = op_q;
    key_d        = key_q;
    blk_d        = blk_q;
    scan_d       = scan_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_blk_d    = hit_blk_q;
    hit_refs_d   = hit_refs_q;
    free_vld_d   = free_vld_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    res_blk_d    = res_blk_q;
    res_refs_d   = res_refs_q;
    saved_d      = saved_q;
    shared_d     = shared_q;
    ov_d         = ov_q;
    o_status_d   = o_status_q;
    o_blk_d      = o_blk_q;
    o_refs_d     = o_refs_q;
    o_saved_d    = o_saved_q;
    o_shared_d   = o_shared_q;
    key_we_o     = 1'b0;
    key_wdata_o  = '0;
    dat_we_o     = 1'b0;
    dat_wdata_o  = '0;
    waddr_o      = hit_q ? hit_idx_q : free_idx_q;
    re_o         = issue;
    raddr_o      = scan_q[AW-1:0];
    in_i.ready   = (state_q == S_IDLE);

    if (out_o.valid && out_o.ready) ov_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        key_we_o = 1'b1;
        waddr_o  = clr_q;
        clr_d    = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          op_d         = in_i.mode;
          key_d        = in_i.checksum;
          blk_d        = in_i.block_number;
          scan_d       = '0;
          hit_d        = 1'b0;
          free_vld_d   = 1'b0;
          res_status_d = early_status;
          res_blk_d    = '0;
          res_refs_d   = '0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_d    = scan_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[AW-1:0];
        end
        if (match) begin
          hit_d      = 1'b1;
          hit_idx_d  = cmp_idx_q;
          hit_blk_d  = dat_rdata_i[DMEM_W-1:REF_W];
          hit_refs_d = dat_rdata_i[REF_W-1:0];
        end
        if (cmp_vld_q && !rd_valid && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_idx_d = cmp_idx_q;
        end
      end
      S_UPD: begin
        res_status_d = ST_OK;
        res_blk_d    = '0;
        res_refs_d   = '0;
        case (op_q)
          OP_RECORD: begin
            if (hit_q) begin
              dat_we_o    = 1'b1;
              dat_wdata_o = {hit_blk_q, refs_inc};
              saved_d     = saved_q + {{(TOT_W - BS_W){1'b0}}, cfg_i.block_size};
              shared_d    = shared_q + 1'b1;
              res_blk_d   = hit_blk_q;
              res_refs_d  = refs_inc;
            end else if (free_vld_q) begin
              key_we_o    = 1'b1;
              key_wdata_o = {1'b1, key_q};
              dat_we_o    = 1'b1;
              dat_wdata_o = {blk_q, REF_W'(1)};
              res_blk_d   = blk_q;
              res_refs_d  = REF_W'(1);
            end else begin
              res_status_d = ST_FULL;
            end
          end
          OP_RESOLVE: begin
            if (hit_q) begin
              res_blk_d  = hit_blk_q;
              res_refs_d = hit_refs_q;
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end
          OP_RELEASE: begin
            if (hit_q) begin
              res_blk_d = hit_blk_q;
              if (hit_refs_q <= REF_W'(1)) begin
                key_we_o    = 1'b1;
                key_wdata_o = {1'b0, key_q};
              end else begin
                dat_we_o    = 1'b1;
                dat_wdata_o = {hit_blk_q, refs_dec};
                res_refs_d  = refs_dec;
              end
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end
          default: begin
            res_status_d = ST_INVALID;
          end
        endcase
      end
      S_RESP: begin
        if (can_load) begin
          ov_d       = 1'b1;
          o_status_d = res_status_q;
          o_blk_d    = res_blk_q;
          o_refs_d   = res_refs_q;
          o_saved_d  = saved_q;
          o_shared_d = shared_q;
        end
      end
      default: begin
        ov_d = ov_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      scan_q     <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_vld_q <= 1'b0;
      saved_q    <= '0;
      shared_q   <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      scan_q     <= scan_d;
      cmp_vld_q  <= cmp_vld_d;
      hit_q      <= hit_d;
      free_vld_q <= free_vld_d;
      saved_q    <= saved_d;
      shared_q   <= shared_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    blk_q        <= blk_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_idx_q    <= hit_idx_d;
    hit_blk_q    <= hit_blk_d;
    hit_refs_q   <= hit_refs_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    res_blk_q    <= res_blk_d;
    res_refs_q   <= res_refs_d;
    o_status_q   <= o_status_d;
    o_blk_q      <= o_blk_d;
    o_refs_q     <= o_refs_d;
    o_saved_q    <= o_saved_d;
    o_shared_q   <= o_shared_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = o_status_q;
  assign out_o.found_block   = o_blk_q;
  assign out_o.ref_count     = o_refs_q;
  assign out_o.bytes_saved   = o_saved_q;
  assign out_o.shared_blocks = o_shared_q;

  assign sts_o.saved  = saved_q;
  assign sts_o.shared = shared_q;

endmodule

/* hw/rtl/dedup_refcount_table.sv */
// search: words that need no search go straight to the response; a search reads
//   one entry per cycle from the key and data memories and stops at the first
//   hit or after the last entry (record, resolve, release)
// throughput: one word at a time; the next word is taken once the result is
//   in the output register
// reset: counters clear and config registers take their reset values at once;
//   then a clearing pass marks every key entry invalid before the first word is
//   taken
module dedup_refcount_table #(
  parameter int unsigned ENTRIES = drc_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [drc_pkg::CFG_W-1:0]     cfg_wdata_i,
  drc_in_if.sink                        in_i,
  drc_out_if.source                     out_o
);
  import drc_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);

  cfg_t cfg_q, cfg_d;
  sts_t sts;

  logic              key_we;
  logic [KMEM_W-1:0] key_wdata;
  logic              dat_we;
  logic [DMEM_W-1:0] dat_wdata;
  logic [AW-1:0]     waddr;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [KMEM_W-1:0] key_rdata;
  logic [DMEM_W-1:0] dat_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLED:    cfg_d.enabled    = cfg_wdata_i[0];
        REG_MODE:       cfg_d.dmode      = cfg_wdata_i[DMODE_W-1:0];
        REG_BLOCK_SIZE: cfg_d.block_size = cfg_wdata_i[BS_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled    <= ENABLED_RST;
      cfg_q.dmode      <= MODE_RST;
      cfg_q.block_size <= BLOCK_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  drc_ram #(
    .WIDTH (KMEM_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  drc_ram #(
    .WIDTH (DMEM_W),
    .DEPTH (ENTRIES)
  ) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (waddr),
    .wdata_i (dat_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (dat_rdata)
  );

  drc_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .out_o       (out_o),
    .key_we_o    (key_we),
    .key_wdata_o (key_wdata),
    .dat_we_o    (dat_we),
    .dat_wdata_o (dat_wdata),
    .waddr_o     (waddr),
    .re_o        (re),
    .raddr_o     (raddr),
    .key_rdata_i (key_rdata),
    .dat_rdata_i (dat_rdata),
    .sts_o       (sts)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken twice in a row");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_we || dat_we) |-> !in_i.ready)
    else $error("table written while open for input");

  a_shared_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(sts.shared) |-> sts.shared == $past(sts.shared) + 64'd1)
    else $error("shared block total moved by more than one");

  a_saved_with_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(sts.shared) |-> $stable(sts.saved))
    else $error("saved byte total moved without a hit");

endmodule
